// ===== rtl/gol24_pkg.sv =====
// Shared types, constants and syndrome helpers for the extended Golay (24,12) decoder.
package gol24_pkg;

    localparam int HALF_W   = 12;
    localparam int CW_W     = 24;
    localparam int CNT_W    = 3;
    localparam int POS_W    = 5;
    localparam int TBL_DEPTH = 1 << HALF_W;

    localparam logic [HALF_W-1:0] HALF_MASK    = 12'hfff;
    localparam logic [CNT_W-1:0]  UNCORR_COUNT = 3'd4;
    localparam logic [CNT_W-1:0]  COUNT_ZERO   = 3'd0;
    localparam logic [CNT_W-1:0]  COUNT_ONE    = 3'd1;
    localparam logic [CNT_W-1:0]  COUNT_TWO    = 3'd2;
    localparam logic [CNT_W-1:0]  COUNT_THREE  = 3'd3;

    // Bit positions of the 24-bit word; positions below HALF_POS are parity bits
    localparam logic [POS_W-1:0] HALF_POS = 5'd12;
    localparam logic [POS_W-1:0] LAST_POS = 5'd23;

    // Parity matrix rows; row i belongs to parity bit (11 - i)
    localparam logic [HALF_W-1:0] ROWS [HALF_W] = '{
        12'ha4f, 12'hf68, 12'h7b4, 12'h3da,
        12'h1ed, 12'hab9, 12'hf13, 12'hdc6,
        12'h6e3, 12'h93e, 12'h49f, 12'hc75
    };

    // One table entry: correction for the data half and the error weight
    typedef struct packed {
        logic [HALF_W-1:0] corr;
        logic [CNT_W-1:0]  count;
    } gol24_entry_t;

    // Write port of the syndrome table
    typedef struct packed {
        logic              en;
        logic [HALF_W-1:0] addr;
        gol24_entry_t      entry;
    } gol24_wr_t;

    // Syndrome of a single error at bit position pos
    function automatic logic [HALF_W-1:0] unit_syn(input logic [POS_W-1:0] pos);
        logic [HALF_W-1:0] s;
        if (pos < HALF_POS)
            s = ROWS[4'(LAST_POS - HALF_POS - pos)];
        else
            s = HALF_W'(1) << (pos - HALF_POS);
        return s;
    endfunction

    // Data-half bits flipped by a single error at bit position pos
    function automatic logic [HALF_W-1:0] unit_upper(input logic [POS_W-1:0] pos);
        logic [HALF_W-1:0] u;
        if (pos < HALF_POS)
            u = '0;
        else
            u = HALF_W'(1) << (pos - HALF_POS);
        return u;
    endfunction

    // Parity half run through the matrix: XOR of rows for the set parity bits
    function automatic logic [HALF_W-1:0] parity_syn(input logic [HALF_W-1:0] parity);
        logic [HALF_W-1:0] s;
        s = '0;
        for (int i = 0; i < HALF_W; i++)
        begin
            if (parity[HALF_W-1-i])
                s = s ^ ROWS[i];
        end
        return s;
    endfunction

endpackage

// ===== rtl/gol24_cw_if.sv =====
// Handshake channel carrying one received codeword.
interface gol24_cw_if;
    import gol24_pkg::*;

    logic            valid;
    logic            ready;
    logic [CW_W-1:0] codeword;

    modport source (output valid, output codeword, input ready);
    modport sink   (input valid, input codeword, output ready);
endinterface

// ===== rtl/gol24_res_if.sv =====
// Handshake channel carrying one decoded result.
interface gol24_res_if;
    import gol24_pkg::*;

    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] corrected_data;
    logic [CNT_W-1:0]  error_count;

    modport source (output valid, output corrected_data, output error_count, input ready);
    modport sink   (input valid, input corrected_data, input error_count, output ready);
endinterface

// ===== rtl/golay24_syndrome_decoder.sv =====
// Top level of the extended Golay (24,12) decoder: syndrome, table lookup, output register.
//
//  channel  dir  payload                              transfer when
//  code     in   codeword[23:0]                       code.valid && code.ready
//  result   out  corrected_data[11:0], error_count[2:0]  result.valid && result.ready
//
// One codeword per cycle unless a stalled result backs up the pipeline; a result passes
// through the table read register, then the output register. The table memory's single
// read port sets the rate. After reset the table is built by 4096 clear writes and 2324
// pattern writes; code.ready stays low until then.
// A stalled result holds the output register and the lookup stage behind it;
// input is taken again as soon as the lookup stage can move.
module golay24_syndrome_decoder (
    input  logic        clk,
    input  logic        rst_n,
    gol24_cw_if.sink    code,
    gol24_res_if.source result
);
    import gol24_pkg::*;

    gol24_wr_t         wr;
    logic              table_done;
    gol24_entry_t      lookup;
    logic [HALF_W-1:0] syn;
    logic              in_xfer;
    logic              s1_move;

    logic              s1_valid_reg, s1_valid_next;
    logic [HALF_W-1:0] s1_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [HALF_W-1:0] out_data_reg;
    logic [CNT_W-1:0]  out_count_reg;

    gol24_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .done  (table_done)
    );

    // Syndrome of the incoming word
    assign syn = code.codeword[CW_W-1:HALF_W] ^ parity_syn(code.codeword[HALF_W-1:0]);

    gol24_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (in_xfer),
        .rd_addr (syn),
        .rd_data (lookup)
    );

    // Handshake and pipeline flow
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign code.ready = table_done && (!s1_valid_reg || s1_move);
    assign in_xfer    = code.valid && code.ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_data_reg <= code.codeword[CW_W-1:HALF_W];
        if (s1_move)
        begin
            out_data_reg  <= s1_data_reg ^ lookup.corr;
            out_count_reg <= lookup.count;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.corrected_data = out_data_reg;
    assign result.error_count    = out_count_reg;

endmodule

// ===== rtl/gol24_fill.sv =====
// Post-reset sequencer that builds the syndrome table: a clear sweep, then one
// write per error pattern of weight one to three.
module gol24_fill (
    input  logic                clk,
    input  logic                rst_n,
    output gol24_pkg::gol24_wr_t wr,
    output logic                done
);
    import gol24_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_FILL1 = 5'b00010,
        ST_FILL2 = 5'b00100,
        ST_FILL3 = 5'b01000,
        ST_RUN   = 5'b10000
    } fill_state_t;

    fill_state_t       state_reg, state_next;
    logic [HALF_W-1:0] addr_reg, addr_next;
    logic [POS_W-1:0]  i_reg, i_next;
    logic [POS_W-1:0]  j_reg, j_next;
    logic [POS_W-1:0]  k_reg, k_next;

    logic [HALF_W-1:0] syn_i, syn_j, syn_k;
    logic [HALF_W-1:0] up_i, up_j, up_k;

    // Per-position syndrome and data-half terms
    assign syn_i = unit_syn(i_reg);
    assign syn_j = unit_syn(j_reg);
    assign syn_k = unit_syn(k_reg);
    assign up_i  = unit_upper(i_reg);
    assign up_j  = unit_upper(j_reg);
    assign up_k  = unit_upper(k_reg);

    // Pattern enumeration, i < j < k
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        wr.en      = 1'b1;
        wr.addr    = addr_reg;
        wr.entry   = '{corr: HALF_MASK, count: UNCORR_COUNT};
        unique case (state_reg)
            ST_CLEAR:
            begin
                // syndrome zero holds the no-error entry
                if (addr_reg == '0)
                    wr.entry = '{corr: '0, count: COUNT_ZERO};
                addr_next = addr_reg + 1'b1;
                if (addr_reg == HALF_MASK)
                begin
                    state_next = ST_FILL1;
                    i_next     = '0;
                end
            end
            ST_FILL1:
            begin
                wr.addr  = syn_i;
                wr.entry = '{corr: up_i, count: COUNT_ONE};
                if (i_reg == LAST_POS)
                begin
                    state_next = ST_FILL2;
                    i_next     = 5'd0;
                    j_next     = 5'd1;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            ST_FILL2:
            begin
                wr.addr  = syn_i ^ syn_j;
                wr.entry = '{corr: up_i ^ up_j, count: COUNT_TWO};
                if (j_reg == LAST_POS)
                begin
                    if (i_reg == LAST_POS - 5'd1)
                    begin
                        state_next = ST_FILL3;
                        i_next     = 5'd0;
                        j_next     = 5'd1;
                        k_next     = 5'd2;
                    end
                    else
                    begin
                        i_next = i_reg + 5'd1;
                        j_next = i_reg + 5'd2;
                    end
                end
                else
                    j_next = j_reg + 1'b1;
            end
            ST_FILL3:
            begin
                wr.addr  = syn_i ^ syn_j ^ syn_k;
                wr.entry = '{corr: up_i ^ up_j ^ up_k, count: COUNT_THREE};
                if (k_reg == LAST_POS)
                begin
                    if (j_reg == LAST_POS - 5'd1)
                    begin
                        if (i_reg == LAST_POS - 5'd2)
                            state_next = ST_RUN;
                        else
                        begin
                            i_next = i_reg + 5'd1;
                            j_next = i_reg + 5'd2;
                            k_next = i_reg + 5'd3;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 5'd1;
                        k_next = j_reg + 5'd2;
                    end
                end
                else
                    k_next = k_reg + 1'b1;
            end
            ST_RUN:
            begin
                wr.en = 1'b0;
            end
            default:
            begin
                wr.en      = 1'b0;
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign done = (state_reg == ST_RUN);

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== rtl/gol24_table.sv =====
// Syndrome table: 4096 entries, one write port, one registered read port.
module gol24_table (
    input  logic                       clk,
    input  gol24_pkg::gol24_wr_t       wr,
    input  logic                       rd_en,
    input  logic [gol24_pkg::HALF_W-1:0] rd_addr,
    output gol24_pkg::gol24_entry_t    rd_data
);
    import gol24_pkg::*;

    gol24_entry_t mem [TBL_DEPTH];
    gol24_entry_t rd_data_reg;

    // Writes happen only while the table is built; reads only afterwards,
    // so the two ports never touch the same entry in one cycle.
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.entry;
    end

    // Read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the extended Golay (24,12) syndrome decoder.
module tb;
    import gol24_pkg::*;

    localparam int NUM_RANDOM  = 1200;
    localparam int MAX_WAIT    = 11;
    localparam int IDLE_LIMIT  = 30000;
    localparam int SHOW_ERRORS = 10;
    localparam int DRAIN_CYCLES = 8;

    // Parity matrix rows; row i belongs to parity bit (11 - i)
    localparam logic [HALF_W-1:0] MATRIX [HALF_W] = '{
        12'ha4f, 12'hf68, 12'h7b4, 12'h3da,
        12'h1ed, 12'hab9, 12'hf13, 12'hdc6,
        12'h6e3, 12'h93e, 12'h49f, 12'hc75
    };

    typedef struct {
        logic [CW_W-1:0]   word;
        logic [HALF_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } decode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gol24_cw_if  code_ch ();
    gol24_res_if res_ch ();

    golay24_syndrome_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .code   (code_ch),
        .result (res_ch)
    );

    // Syndrome table: data-half correction and error weight per syndrome
    logic [HALF_W-1:0] fix_pattern [TBL_DEPTH];
    logic [CNT_W-1:0]  fix_weight  [TBL_DEPTH];
    bit                fix_known   [TBL_DEPTH];

    logic [CW_W-1:0] word_queue [$];
    decode_t         pending_decodes [$];
    int              total_words;
    int              n_accepted;
    int              n_errors;
    int              send_wait;
    int              recv_wait;
    bit              send_quiet;
    bit              recv_quiet;
    int              idle_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Syndrome contribution of a single bit error at position pos
    function automatic logic [HALF_W-1:0] bit_syndrome(input int pos);
        if (pos < HALF_W)
            return MATRIX[HALF_W-1-pos];
        return HALF_W'(1) << (pos - HALF_W);
    endfunction

    function automatic logic [HALF_W-1:0] data_flip(input int pos);
        if (pos < HALF_W)
            return '0;
        return HALF_W'(1) << (pos - HALF_W);
    endfunction

    function automatic logic [HALF_W-1:0] word_syndrome(input logic [CW_W-1:0] w);
        logic [HALF_W-1:0] s;
        s = '0;
        for (int pos = 0; pos < CW_W; pos++)
        begin
            if (w[pos])
                s = s ^ bit_syndrome(pos);
        end
        return s;
    endfunction

    // Keep the lightest pattern seen for each syndrome
    function automatic void note_pattern(input logic [HALF_W-1:0] s,
                                         input logic [HALF_W-1:0] fix,
                                         input logic [CNT_W-1:0] weight);
        if (!fix_known[s])
        begin
            fix_known[s]   = 1'b1;
            fix_pattern[s] = fix;
            fix_weight[s]  = weight;
        end
    endfunction

    function automatic void build_fix_table();
        for (int s = 0; s < TBL_DEPTH; s++)
        begin
            fix_known[s]   = 1'b0;
            fix_pattern[s] = HALF_MASK;
            fix_weight[s]  = UNCORR_COUNT;
        end
        note_pattern('0, '0, COUNT_ZERO);
        for (int i = 0; i < CW_W; i++)
            note_pattern(bit_syndrome(i), data_flip(i), COUNT_ONE);
        for (int i = 0; i < CW_W; i++)
            for (int j = i + 1; j < CW_W; j++)
                note_pattern(bit_syndrome(i) ^ bit_syndrome(j),
                             data_flip(i) ^ data_flip(j), COUNT_TWO);
        for (int i = 0; i < CW_W; i++)
            for (int j = i + 1; j < CW_W; j++)
                for (int k = j + 1; k < CW_W; k++)
                    note_pattern(bit_syndrome(i) ^ bit_syndrome(j) ^ bit_syndrome(k),
                                 data_flip(i) ^ data_flip(j) ^ data_flip(k),
                                 COUNT_THREE);
    endfunction

    function automatic decode_t golay_decode(input logic [CW_W-1:0] w);
        decode_t d;
        logic [HALF_W-1:0] s;
        s       = word_syndrome(w);
        d.word  = w;
        d.data  = w[CW_W-1:HALF_W] ^ fix_pattern[s];
        d.count = fix_weight[s];
        return d;
    endfunction

    // Error-free word whose parity half is p: data half equals P(p)
    function automatic logic [CW_W-1:0] clean_word(input logic [HALF_W-1:0] p);
        return {word_syndrome({{HALF_W{1'b0}}, p}), p};
    endfunction

    // Flip n distinct bits chosen in positions lo..hi
    function automatic logic [CW_W-1:0] flip_bits(input logic [CW_W-1:0] w, input int n,
                                                  input int lo, input int hi);
        logic [CW_W-1:0] mask;
        int pos;
        int done;
        mask = '0;
        done = 0;
        while (done < n)
        begin
            pos = $urandom_range(hi, lo);
            if (!mask[pos])
            begin
                mask[pos] = 1'b1;
                done++;
            end
        end
        return w ^ mask;
    endfunction

    function automatic int draw_wait(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(MAX_WAIT, 0);
    endfunction

    // Driver: one codeword per transfer, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_ch.valid    <= 1'b0;
            code_ch.codeword <= '0;
            send_wait        <= 0;
            send_quiet       <= 1'b0;
        end
        else if (!(code_ch.valid && !code_ch.ready))
        begin
            if (code_ch.valid)
            begin
                pending_decodes.push_back(golay_decode(code_ch.codeword));
                n_accepted++;
            end
            if (send_wait > 0)
            begin
                code_ch.valid <= 1'b0;
                send_wait     <= send_wait - 1;
            end
            else if (word_queue.size() > 0)
            begin
                code_ch.valid    <= 1'b1;
                code_ch.codeword <= word_queue.pop_front();
                if ($urandom_range(39, 0) == 0)
                    send_quiet <= !send_quiet;
                send_wait <= draw_wait(send_quiet);
            end
            else
                code_ch.valid <= 1'b0;
        end
    end

    // Monitor: compare each result transfer with the oldest expected decode
    always @(posedge clk or negedge rst_n)
    begin
        decode_t want;
        int      stall;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_wait    <= 0;
            recv_quiet   <= 1'b0;
        end
        else if (res_ch.valid && res_ch.ready)
        begin
            if (pending_decodes.size() == 0)
            begin
                n_errors++;
                if (n_errors <= SHOW_ERRORS)
                    $display("unexpected result: data %03h count %0d",
                             res_ch.corrected_data, res_ch.error_count);
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (res_ch.corrected_data !== want.data || res_ch.error_count !== want.count)
                begin
                    n_errors++;
                    if (n_errors <= SHOW_ERRORS)
                        $display("word %06h: expected %03h/%0d, got %03h/%0d",
                                 want.word, want.data, want.count,
                                 res_ch.corrected_data, res_ch.error_count);
                end
            end
            if ($urandom_range(39, 0) == 0)
                recv_quiet <= !recv_quiet;
            stall = draw_wait(recv_quiet);
            recv_wait    <= stall;
            res_ch.ready <= (stall == 0);
        end
        else if (recv_wait > 0)
        begin
            recv_wait    <= recv_wait - 1;
            res_ch.ready <= (recv_wait == 1);
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((code_ch.valid && code_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [CW_W-1:0] base;
        int pick;
        code_ch.valid    = 1'b0;
        code_ch.codeword = '0;
        res_ch.ready     = 1'b0;
        n_accepted       = 0;
        n_errors         = 0;
        build_fix_table();

        // Directed: extremes, clean words, and each error class
        word_queue.push_back(24'h000000);
        word_queue.push_back(24'hffffff);
        word_queue.push_back(24'hfff000);
        word_queue.push_back(24'h000fff);
        word_queue.push_back(24'h800000);
        word_queue.push_back(24'h000001);
        word_queue.push_back(clean_word(12'hfff));
        base = clean_word(HALF_W'($urandom));
        word_queue.push_back(base);
        word_queue.push_back(flip_bits(base, 1, HALF_W, CW_W - 1));
        word_queue.push_back(flip_bits(base, 1, 0, HALF_W - 1));
        word_queue.push_back(flip_bits(base, 2, HALF_W, CW_W - 1));
        word_queue.push_back(flip_bits(base, 2, 0, HALF_W - 1));
        word_queue.push_back(flip_bits(base, 3, HALF_W, CW_W - 1));
        word_queue.push_back(flip_bits(base, 3, 0, HALF_W - 1));
        word_queue.push_back(flip_bits(base, 3, 0, CW_W - 1));
        // Four errors never correct
        word_queue.push_back(flip_bits(base, 4, 0, CW_W - 1));
        word_queue.push_back(flip_bits(clean_word(12'h000), 4, 0, CW_W - 1));
        word_queue.push_back(flip_bits(clean_word(12'hfff), 2, 10, 13));
        word_queue.push_back(CW_W'($urandom));
        word_queue.push_back(CW_W'($urandom));

        // Random: mostly codewords with 0..3 errors, some uncorrectable, some noise
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            pick = $urandom_range(99, 0);
            base = clean_word(HALF_W'($urandom));
            if (pick < 70)
                word_queue.push_back(flip_bits(base, $urandom_range(3, 0), 0, CW_W - 1));
            else if (pick < 85)
                word_queue.push_back(flip_bits(base, 4, 0, CW_W - 1));
            else
                word_queue.push_back(CW_W'($urandom));
        end
        total_words = word_queue.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < total_words)
            @(posedge clk);
        while (pending_decodes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0 && pending_decodes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== golay24_syndrome_decoder.f =====
rtl/gol24_pkg.sv
rtl/gol24_cw_if.sv
rtl/gol24_res_if.sv
rtl/gol24_fill.sv
rtl/gol24_table.sv
rtl/golay24_syndrome_decoder.sv
tb/tb.sv
